### src/ascon_pkg.sv
// ----------------------------------------------------------------------------
// ascon_pkg: shared types, constants and round logic for the Ascon-128 cipher
// Holds the state encoding, the controller/datapath command and status
// structs, and the permutation round function.
// ----------------------------------------------------------------------------
package ascon_pkg;

  localparam logic [63:0] IV_128      = 64'h80400c0600000000;
  localparam logic [3:0]  LAST_ROUND  = 4'd11;
  localparam logic [3:0]  HALF_START  = 4'd6;
  localparam logic [3:0]  FULL_START  = 4'd0;
  localparam logic [3:0]  FULL_BYTES  = 4'd8;
  localparam logic [2:0]  MAX_PARTIAL = 3'd7;
  localparam logic [7:0]  PAD_BYTE    = 8'h80;

  typedef logic [4:0][63:0] lanes_t;

  typedef enum logic [1:0] {
    MODE_AD    = 2'd0,
    MODE_ENC   = 2'd1,
    MODE_DEC   = 2'd2,
    MODE_FINAL = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_KEY_HIGH   = 2'd0,
    REG_KEY_LOW    = 2'd1,
    REG_NONCE_HIGH = 2'd2,
    REG_NONCE_LOW  = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT_LOAD,
    ST_INIT_ROUND,
    ST_INIT_KEY,
    ST_ABSORB,
    ST_ROUND,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       latch_item;
    logic       load_init;
    logic       init_key;
    logic       absorb;
    logic       separate;   // flip the domain bit during this absorb
    logic       round_en;
    logic [3:0] round_idx;
    logic       emit_load;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  last;
  } sts_t;

  function automatic logic [63:0] rotr(input logic [63:0] v, input int n);
    rotr = (v >> n) | (v << (64 - n));
  endfunction

  // Mask of the first n bytes, first byte in the top bits.
  function automatic logic [63:0] byte_mask(input logic [2:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (3'(i) < n) m[63 - 8 * i -: 8] = 8'hff;
    end
    byte_mask = m;
  endfunction

  // 0x80 in byte position n, counted from the top.
  function automatic logic [63:0] pad_bits(input logic [2:0] n);
    logic [63:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (3'(i) == n) p[63 - 8 * i -: 8] = PAD_BYTE;
    end
    pad_bits = p;
  endfunction

  function automatic lanes_t perm_round(input lanes_t s, input logic [3:0] r);
    logic [63:0] a, b, c, d, e, t0, t1, t2, t3, t4;
    lanes_t o;
    a = s[0]; b = s[1]; c = s[2]; d = s[3]; e = s[4];
    c = c ^ {56'd0, 4'(4'd15 - r), r};
    a = a ^ e; e = e ^ d; c = c ^ b;
    t0 = ~a & b; t1 = ~b & c; t2 = ~c & d; t3 = ~d & e; t4 = ~e & a;
    a = a ^ t1; b = b ^ t2; c = c ^ t3; d = d ^ t4; e = e ^ t0;
    b = b ^ a; a = a ^ e; d = d ^ c; c = ~c;
    o[0] = a ^ rotr(a, 19) ^ rotr(a, 28);
    o[1] = b ^ rotr(b, 61) ^ rotr(b, 39);
    o[2] = c ^ rotr(c, 1) ^ rotr(c, 6);
    o[3] = d ^ rotr(d, 10) ^ rotr(d, 17);
    o[4] = e ^ rotr(e, 7) ^ rotr(e, 41);
    perm_round = o;
  endfunction

endpackage

### src/ascon_datapath.sv
// ----------------------------------------------------------------------------
// ascon_datapath: state lanes, key/nonce registers, block ops, output regs
// Applies one permutation round per cycle and the absorb/squeeze step that
// the controller commands.
// ----------------------------------------------------------------------------
module ascon_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [63:0]            cfg_data,
  input  logic [1:0]             mode,
  input  logic [63:0]            data_block,
  input  logic [3:0]             valid_bytes,
  input  logic                   last_block,
  input  logic [63:0]            expected_tag_high,
  input  logic [63:0]            expected_tag_low,
  input  ascon_pkg::cmd_t        cmd,
  output ascon_pkg::sts_t        sts,
  output logic [63:0]            out_block,
  output logic [3:0]             out_bytes,
  output logic [63:0]            tag_high,
  output logic [63:0]            tag_low,
  output logic                   tag_match,
  output logic                   is_tag_result
);

  logic [63:0] key_high, key_low, nonce_high, nonce_low;
  ascon_pkg::lanes_t lanes, lanes_next;
  ascon_pkg::mode_t  item_mode;
  logic [63:0] item_block, exp_high, exp_low;
  logic [3:0]  item_bytes;
  logic        item_last;
  logic [63:0] res, res_next;
  logic [3:0]  res_bytes, res_bytes_next;

  logic [2:0]  n_sat;
  logic [63:0] mask, pad, cm, th, tl;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high   <= '0;
      key_low    <= '0;
      nonce_high <= '0;
      nonce_low  <= '0;
    end else if (cfg_we) begin
      case (ascon_pkg::reg_index_t'(cfg_index))
        ascon_pkg::REG_KEY_HIGH:   key_high   <= cfg_data;
        ascon_pkg::REG_KEY_LOW:    key_low    <= cfg_data;
        ascon_pkg::REG_NONCE_HIGH: nonce_high <= cfg_data;
        ascon_pkg::REG_NONCE_LOW:  nonce_low  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      item_mode  <= ascon_pkg::mode_t'(mode);
      item_block <= data_block;
      item_bytes <= valid_bytes;
      item_last  <= last_block;
      exp_high   <= expected_tag_high;
      exp_low    <= expected_tag_low;
    end
  end

  assign sts.mode = item_mode;
  assign sts.last = item_last;

  // Saturate the partial-block byte count at seven.
  assign n_sat = (item_bytes > 4'(ascon_pkg::MAX_PARTIAL)) ? ascon_pkg::MAX_PARTIAL
                                                           : item_bytes[2:0];
  assign mask  = ascon_pkg::byte_mask(n_sat);
  assign pad   = ascon_pkg::pad_bits(n_sat);
  assign cm    = item_block & mask;
  assign th    = lanes[3] ^ key_high;
  assign tl    = lanes[4] ^ key_low;

  always_comb begin
    lanes_next     = lanes;
    res_next       = res;
    res_bytes_next = res_bytes;
    if (cmd.load_init) begin
      lanes_next[0] = ascon_pkg::IV_128;
      lanes_next[1] = key_high;
      lanes_next[2] = key_low;
      lanes_next[3] = nonce_high;
      lanes_next[4] = nonce_low;
    end else if (cmd.init_key) begin
      lanes_next[3] = lanes[3] ^ key_high;
      lanes_next[4] = lanes[4] ^ key_low;
    end else if (cmd.round_en) begin
      lanes_next = ascon_pkg::perm_round(lanes, cmd.round_idx);
    end else if (cmd.absorb) begin
      lanes_next[4] = lanes[4] ^ {63'd0, cmd.separate};
      case (item_mode)
        ascon_pkg::MODE_AD: begin
          lanes_next[0] = lanes[0] ^ (item_last ? (cm | pad) : item_block);
        end
        ascon_pkg::MODE_ENC: begin
          if (item_last) begin
            lanes_next[0]  = lanes[0] ^ (cm | pad);
            res_next       = (lanes[0] ^ (cm | pad)) & mask;
            res_bytes_next = {1'b0, n_sat};
          end else begin
            lanes_next[0]  = lanes[0] ^ item_block;
            res_next       = lanes[0] ^ item_block;
            res_bytes_next = ascon_pkg::FULL_BYTES;
          end
        end
        ascon_pkg::MODE_DEC: begin
          if (item_last) begin
            res_next       = (lanes[0] ^ cm) & mask;
            lanes_next[0]  = ((lanes[0] & ~mask) | cm) ^ pad;
            res_bytes_next = {1'b0, n_sat};
          end else begin
            res_next       = lanes[0] ^ item_block;
            lanes_next[0]  = item_block;
            res_bytes_next = ascon_pkg::FULL_BYTES;
          end
        end
        ascon_pkg::MODE_FINAL: begin
          lanes_next[1] = lanes[1] ^ key_high;
          lanes_next[2] = lanes[2] ^ key_low;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    lanes     <= lanes_next;
    res       <= res_next;
    res_bytes <= res_bytes_next;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      if (item_mode == ascon_pkg::MODE_FINAL) begin
        out_block     <= '0;
        out_bytes     <= '0;
        tag_high      <= th;
        tag_low       <= tl;
        tag_match     <= (th == exp_high) && (tl == exp_low);
        is_tag_result <= 1'b1;
      end else begin
        out_block     <= res;
        out_bytes     <= res_bytes;
        tag_high      <= '0;
        tag_low       <= '0;
        tag_match     <= 1'b0;
        is_tag_result <= 1'b0;
      end
    end
  end

endmodule

### src/ascon_ctrl.sv
// ----------------------------------------------------------------------------
// ascon_ctrl: sequencing state machine for the Ascon-128 cipher
// Tracks message and domain state, counts rounds, owns both handshakes.
// ----------------------------------------------------------------------------
module ascon_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  ascon_pkg::sts_t sts,
  output ascon_pkg::cmd_t cmd
);

  ascon_pkg::state_t state, state_next;
  logic [3:0] rnd, rnd_next;
  logic msg_open, msg_open_next;
  logic dps, dps_next;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ascon_pkg::ST_IDLE;
      rnd       <= '0;
      msg_open  <= 1'b0;
      dps       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rnd       <= rnd_next;
      msg_open  <= msg_open_next;
      dps       <= dps_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_stall = (state != ascon_pkg::ST_IDLE);

  always_comb begin
    state_next     = state;
    rnd_next       = rnd;
    msg_open_next  = msg_open;
    dps_next       = dps;
    out_valid_next = out_valid && out_stall;
    cmd            = '0;
    cmd.round_idx  = rnd;
    case (state)
      ascon_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.latch_item = 1'b1;
          state_next     = msg_open ? ascon_pkg::ST_ABSORB : ascon_pkg::ST_INIT_LOAD;
        end
      end
      ascon_pkg::ST_INIT_LOAD: begin
        cmd.load_init = 1'b1;
        rnd_next      = ascon_pkg::FULL_START;
        state_next    = ascon_pkg::ST_INIT_ROUND;
      end
      ascon_pkg::ST_INIT_ROUND: begin
        cmd.round_en = 1'b1;
        rnd_next     = rnd + 4'd1;
        if (rnd == ascon_pkg::LAST_ROUND) state_next = ascon_pkg::ST_INIT_KEY;
      end
      ascon_pkg::ST_INIT_KEY: begin
        cmd.init_key  = 1'b1;
        msg_open_next = 1'b1;
        dps_next      = 1'b0;
        state_next    = ascon_pkg::ST_ABSORB;
      end
      ascon_pkg::ST_ABSORB: begin
        if (sts.mode == ascon_pkg::MODE_AD) begin
          if (dps) begin
            state_next = ascon_pkg::ST_IDLE;
          end else begin
            cmd.absorb = 1'b1;
            rnd_next   = ascon_pkg::HALF_START;
            state_next = ascon_pkg::ST_ROUND;
          end
        end else begin
          cmd.absorb   = 1'b1;
          cmd.separate = !dps;
          dps_next     = 1'b1;
          if (sts.mode == ascon_pkg::MODE_FINAL) begin
            rnd_next   = ascon_pkg::FULL_START;
            state_next = ascon_pkg::ST_ROUND;
          end else if (sts.last) begin
            state_next = ascon_pkg::ST_EMIT;
          end else begin
            rnd_next   = ascon_pkg::HALF_START;
            state_next = ascon_pkg::ST_ROUND;
          end
        end
      end
      ascon_pkg::ST_ROUND: begin
        cmd.round_en = 1'b1;
        rnd_next     = rnd + 4'd1;
        if (rnd == ascon_pkg::LAST_ROUND) begin
          state_next = (sts.mode == ascon_pkg::MODE_AD) ? ascon_pkg::ST_IDLE
                                                        : ascon_pkg::ST_EMIT;
        end
      end
      ascon_pkg::ST_EMIT: begin
        if (!out_valid || !out_stall) begin
          cmd.emit_load  = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ascon_pkg::ST_IDLE;
          if (sts.mode == ascon_pkg::MODE_FINAL) begin
            msg_open_next = 1'b0;
            dps_next      = 1'b0;
          end
        end
      end
      default: state_next = ascon_pkg::ST_IDLE;
    endcase
  end

endmodule

### src/ascon_aead_cipher.sv
// ----------------------------------------------------------------------------
// ascon_aead_cipher: Ascon-128 authenticated encryption, one block per item
// Channel summary, cycle behavior and reset are described below.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data (key, nonce regs)
//  in      | in_valid/in_stall   | mode, data_block, valid_bytes, last_block,
//          |                     | expected_tag_high, expected_tag_low
//  out     | out_valid/out_stall | out_block, out_bytes, tag_high, tag_low,
//          |                     | tag_match, is_tag_result
//
//  One permutation round per cycle through a single round unit. Per item:
//  full data block accept, absorb, 6 rounds, emit; last block accept, absorb,
//  emit; associated data accept, absorb, 6 rounds (dropped once data began);
//  finalize accept, absorb, 12 rounds, emit; first item adds 12-round init.
//  Synchronous active-high reset clears the key, nonce and message state.
//  A waiting result holds only the next emit, and the input with it.
// ----------------------------------------------------------------------------
module ascon_aead_cipher (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  // input item channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [63:0] data_block,
  input  logic [3:0]  valid_bytes,
  input  logic        last_block,
  input  logic [63:0] expected_tag_high,
  input  logic [63:0] expected_tag_low,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_block,
  output logic [3:0]  out_bytes,
  output logic [63:0] tag_high,
  output logic [63:0] tag_low,
  output logic        tag_match,
  output logic        is_tag_result
);

  ascon_pkg::cmd_t cmd;
  ascon_pkg::sts_t sts;

  // User must keep register writes to idle; unenforced, accepted every cycle.
  assign cfg_ready = 1'b1;

  // Sequence init, absorb, rounds and emit; own both item handshakes.
  ascon_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold the five state lanes, key and nonce, and the output register.
  ascon_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mode              (mode),
    .data_block        (data_block),
    .valid_bytes       (valid_bytes),
    .last_block        (last_block),
    .expected_tag_high (expected_tag_high),
    .expected_tag_low  (expected_tag_low),
    .cmd               (cmd),
    .sts               (sts),
    .out_block         (out_block),
    .out_bytes         (out_bytes),
    .tag_high          (tag_high),
    .tag_low           (tag_low),
    .tag_match         (tag_match),
    .is_tag_result     (is_tag_result)
  );

endmodule
